@@ src/lifo_stack_with_dump_top_assert.svh @@
// Assertion macros for the LIFO stack with dump.
`ifndef LIFO_STACK_WITH_DUMP_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_DUMP_TOP_ASSERT_SVH
`ifndef SYNTH
`define LSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `LSD_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define LSD_ASSERT(lbl, clk, rstn, prop, msg)
`define LSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ src/lsd_pkg.sv @@
// Types and constants shared by the LIFO stack with dump.
`timescale 1ns / 1ps
package lsd_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DUMP  = 3'd3,
    OP_CLEAR = 3'd4
  } lsd_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } lsd_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DUMP
  } lsd_state_e;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        clear;
    logic        rd_top;
    logic        rd_next;
    logic        out_load;
    logic        out_from_mem;
    lsd_status_e out_status;
    logic        out_last;
  } lsd_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic idx_zero;
  } lsd_stat_t;

endpackage

@@ src/lsd_if.sv @@
// Valid/ready channels for operation beats and result beats.
`timescale 1ns / 1ps
interface lsd_in_if;
  logic                           valid;
  logic                           ready;
  logic [lsd_pkg::OP_W-1:0]       op;
  logic [lsd_pkg::WORD_WIDTH-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

interface lsd_out_if;
  logic                           valid;
  logic                           ready;
  logic [lsd_pkg::STATUS_W-1:0]   status;
  logic [lsd_pkg::WORD_WIDTH-1:0] word_out;
  logic [lsd_pkg::COUNT_W-1:0]    entry_count;
  logic                           last;

  modport source (output valid, output status, output word_out, output entry_count,
                  output last, input ready);
  modport sink (input valid, input status, input word_out, input entry_count,
                input last, output ready);
endinterface

@@ src/lsd_datapath.sv @@
// Stack memory, fill count, dump index and result register.
`timescale 1ns / 1ps
`include "lifo_stack_with_dump_top_assert.svh"
module lsd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lsd_pkg::lsd_cmd_t                cmd_i,
  input  logic [lsd_pkg::WORD_WIDTH-1:0]   push_value_i,
  output lsd_pkg::lsd_stat_t               stat_o,
  output logic [lsd_pkg::STATUS_W-1:0]     status_o,
  output logic [lsd_pkg::WORD_WIDTH-1:0]   word_out_o,
  output logic [lsd_pkg::COUNT_W-1:0]      entry_count_o,
  output logic                             last_o
);

  logic [lsd_pkg::WORD_WIDTH-1:0] mem [lsd_pkg::DEPTH];
  logic [lsd_pkg::WORD_WIDTH-1:0] rdata_q;
  logic [lsd_pkg::COUNT_W-1:0]    count_q, count_d, count_dec;
  logic [lsd_pkg::ADDR_W-1:0]     idx_q, idx_d, top_addr, raddr;
  logic                           rd_en;

  logic [lsd_pkg::STATUS_W-1:0]   status_q;
  logic [lsd_pkg::WORD_WIDTH-1:0] word_q;
  logic [lsd_pkg::COUNT_W-1:0]    cnt_out_q;
  logic                           last_q;

  assign count_dec = count_q - 1'b1;
  assign top_addr  = count_dec[lsd_pkg::ADDR_W-1:0];
  assign raddr     = cmd_i.rd_top ? top_addr : idx_q - 1'b1;
  assign rd_en     = cmd_i.rd_top | cmd_i.rd_next;

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_dec;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.rd_top) begin
      idx_d = top_addr;
    end else if (cmd_i.rd_next) begin
      idx_d = idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[lsd_pkg::ADDR_W-1:0]] <= push_value_i;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q  <= cmd_i.out_status;
      word_q    <= cmd_i.out_from_mem ? rdata_q : '0;
      cnt_out_q <= count_d;
      last_q    <= cmd_i.out_last;
    end
  end

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == lsd_pkg::COUNT_W'(lsd_pkg::DEPTH));
  assign stat_o.idx_zero = (idx_q == '0);

  assign status_o      = status_q;
  assign word_out_o    = word_q;
  assign entry_count_o = cnt_out_q;
  assign last_o        = last_q;

  `LSD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= lsd_pkg::COUNT_W'(lsd_pkg::DEPTH), "fill count beyond depth")
  `LSD_ASSERT(a_push_room, clk_i, rst_ni, cmd_i.push |=> count_q == $past(count_q) + 1'b1, "push lost")
  `LSD_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_i.pop && count_q == '0, "pop on empty stack")

endmodule

@@ src/lsd_controller.sv @@
// Operation sequencer and result valid control.
`timescale 1ns / 1ps
`include "lifo_stack_with_dump_top_assert.svh"
module lsd_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lsd_pkg::OP_W-1:0]     op_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  lsd_pkg::lsd_stat_t           stat_i,
  output lsd_pkg::lsd_cmd_t            cmd_o
);

  lsd_pkg::lsd_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free, in_fire;
  lsd_pkg::lsd_op_e    op;

  assign op         = lsd_pkg::lsd_op_e'(op_i);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lsd_pkg::ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsd_pkg::ST_IDLE: begin
        if (in_fire && !stat_i.empty) begin
          if (op == lsd_pkg::OP_POP || op == lsd_pkg::OP_PEEK) begin
            state_d = lsd_pkg::ST_READ;
          end else if (op == lsd_pkg::OP_DUMP) begin
            state_d = lsd_pkg::ST_DUMP;
          end
        end
      end
      lsd_pkg::ST_READ: state_d = lsd_pkg::ST_IDLE;
      lsd_pkg::ST_DUMP: begin
        if (slot_free && stat_i.idx_zero) begin
          state_d = lsd_pkg::ST_IDLE;
        end
      end
      default: state_d = lsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = lsd_pkg::STAT_OK;
    cmd_o.out_last   = 1'b1;
    unique case (state_q)
      lsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            lsd_pkg::OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = lsd_pkg::STAT_OVERFLOW;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            lsd_pkg::OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lsd_pkg::STAT_UNDERFLOW;
              end else begin
                cmd_o.pop    = 1'b1;
                cmd_o.rd_top = 1'b1;
              end
            end
            lsd_pkg::OP_PEEK, lsd_pkg::OP_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lsd_pkg::STAT_UNDERFLOW;
              end else begin
                cmd_o.rd_top = 1'b1;
              end
            end
            lsd_pkg::OP_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            default: cmd_o.out_load = 1'b1;
          endcase
        end
      end
      lsd_pkg::ST_READ: begin
        cmd_o.out_load     = 1'b1;
        cmd_o.out_from_mem = 1'b1;
      end
      lsd_pkg::ST_DUMP: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = stat_i.idx_zero;
          cmd_o.rd_next      = !stat_i.idx_zero;
        end
      end
      default: cmd_o.out_load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `LSD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i && cmd_o.out_load, "result overwritten")
  `LSD_ASSERT(a_read_slot, clk_i, rst_ni, state_q == lsd_pkg::ST_READ |-> !out_valid_q, "read result has no free slot")

endmodule

@@ src/lifo_stack_with_dump_top.sv @@
// Push, clear, full push, empty pop/peek/dump and unused op codes give their result in the
// cycle after the beat is taken; pop and peek go through the registered stack memory read
// of the single-port memory, then the result register. Push, clear and refused ops run at one
// operation per cycle while the output is not stalled; pop and peek hold off the next op until
// the read is done; a dump of N entries streams N result beats, one per cycle unless stalled.
// Reset clears the fill count and control; stack words are not cleared.
`timescale 1ns / 1ps
module lifo_stack_with_dump_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsd_in_if.sink     in_i,
  lsd_out_if.source  out_o
);

  lsd_pkg::lsd_cmd_t  cmd;
  lsd_pkg::lsd_stat_t stat;

  lsd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .op_i       (in_i.op),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_value_i (in_i.push_value),
    .stat_o       (stat),
    .status_o     (out_o.status),
    .word_out_o   (out_o.word_out),
    .entry_count_o(out_o.entry_count),
    .last_o       (out_o.last)
  );

endmodule

@@ tb/lifo_stack_with_dump_top_test.sv @@
// Self-checking test of the LIFO stack with dump: directed and random operations against a predictor.
`timescale 1ns / 1ps
module lifo_stack_with_dump_top_test;
  import lsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEM_TARGET    = 350;
  localparam int MAX_WAIT       = 19;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct {
    lsd_status_e           status;
    logic [WORD_WIDTH-1:0] word;
    logic [COUNT_W-1:0]    count;
    logic                  last;
  } stack_result_t;

  logic clk;
  logic rst_n;

  lsd_in_if  in_bus ();
  lsd_out_if out_bus ();

  lifo_stack_with_dump_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic [WORD_WIDTH-1:0] stack_words [DEPTH];
  int                    stack_fill = 0;
  stack_result_t         pending_results [$];

  int errors          = 0;
  int ops_sent        = 0;
  int beats_checked   = 0;
  int overflows_seen  = 0;
  int underflows_seen = 0;
  int dumps_sent      = 0;
  int quiet_cycles    = 0;
  bit no_gaps         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void queue_result(lsd_status_e status, logic [WORD_WIDTH-1:0] word,
                                       logic last);
    stack_result_t r;
    r.status = status;
    r.word   = word;
    r.count  = COUNT_W'(stack_fill);
    r.last   = last;
    pending_results.push_back(r);
    if (status == STAT_OVERFLOW) overflows_seen++;
    if (status == STAT_UNDERFLOW) underflows_seen++;
  endfunction

  function automatic void predict_stack(logic [OP_W-1:0] op, logic [WORD_WIDTH-1:0] value);
    int i;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          queue_result(STAT_OVERFLOW, '0, 1'b1);
        end else begin
          stack_words[stack_fill] = value;
          stack_fill++;
          queue_result(STAT_OK, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (stack_fill == 0) begin
          queue_result(STAT_UNDERFLOW, '0, 1'b1);
        end else begin
          stack_fill--;
          queue_result(STAT_OK, stack_words[stack_fill], 1'b1);
        end
      end
      OP_PEEK: begin
        if (stack_fill == 0) queue_result(STAT_UNDERFLOW, '0, 1'b1);
        else queue_result(STAT_OK, stack_words[stack_fill-1], 1'b1);
      end
      OP_DUMP: begin
        dumps_sent++;
        if (stack_fill == 0) begin
          queue_result(STAT_UNDERFLOW, '0, 1'b1);
        end else begin
          for (i = stack_fill - 1; i >= 0; i--) begin
            queue_result(STAT_OK, stack_words[i], i == 0);
          end
        end
      end
      OP_CLEAR: begin
        stack_fill = 0;
        queue_result(STAT_OK, '0, 1'b1);
      end
      default: begin
        queue_result(STAT_OK, '0, 1'b1);
      end
    endcase
  endfunction

  // Beat is taken at the edge after the low phase in which valid and ready are seen high.
  task automatic send_op(logic [OP_W-1:0] op, logic [WORD_WIDTH-1:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.push_value <= value;
    do @(negedge clk); while (!in_bus.ready);
    predict_stack(op, value);
    ops_sent++;
    @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_PUSH;
    if (r < 60) return OP_POP;
    if (r < 72) return OP_PEEK;
    if (r < 82) return OP_DUMP;
    if (r < 87) return OP_CLEAR;
    return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  task automatic fill_stack();
    while (stack_fill < DEPTH) send_op(OP_PUSH, $urandom);
  endtask

  task automatic test_empty_stack();
    send_op(OP_POP, $urandom);
    send_op(OP_PEEK, $urandom);
    send_op(OP_DUMP, $urandom);
    send_op(OP_CLEAR, $urandom);
    send_op(OP_SPARE_FIRST, $urandom);
    send_op(OP_W'(OP_SPARE_FIRST + 1), $urandom);
    send_op(OP_SPARE_LAST, $urandom);
  endtask

  task automatic test_word_extremes();
    send_op(OP_PUSH, 32'h0000_0000);
    send_op(OP_PUSH, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 32'hAAAA_AAAA);
    send_op(OP_PUSH, 32'h5555_5555);
    send_op(OP_PEEK, '0);
    send_op(OP_DUMP, '0);
    send_op(OP_POP, '0);
    send_op(OP_POP, '0);
    send_op(OP_PEEK, '0);
  endtask

  task automatic test_single_entry();
    send_op(OP_CLEAR, '0);
    send_op(OP_PUSH, $urandom);
    send_op(OP_DUMP, '0);
    send_op(OP_POP, '0);
    send_op(OP_DUMP, '0);
  endtask

  task automatic test_overflow();
    no_gaps = 1'b1;
    fill_stack();
    no_gaps = 1'b0;
    send_op(OP_PUSH, $urandom);
    send_op(OP_PUSH, $urandom);
    send_op(OP_PEEK, '0);
    send_op(OP_DUMP, '0);
    send_op(OP_CLEAR, '0);
    send_op(OP_PEEK, '0);
  endtask

  task automatic test_random_traffic();
    int kind;
    while (ops_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 11);
      case (kind)
        0: begin
          fill_stack();
          repeat ($urandom_range(1, 3)) send_op(OP_PUSH, $urandom);
          send_op(OP_DUMP, $urandom);
        end
        1: begin
          while (stack_fill > 0) send_op(OP_POP, $urandom);
          send_op(OP_POP, $urandom);
          send_op(OP_PEEK, $urandom);
        end
        2: begin
          send_op(OP_CLEAR, $urandom);
          repeat ($urandom_range(1, 6)) send_op(OP_PUSH, $urandom);
          send_op(OP_DUMP, $urandom);
        end
        default: begin
          repeat ($urandom_range(8, 20)) send_op(pick_op(), $urandom);
        end
      endcase
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(negedge clk); while (!out_bus.valid);
      @(posedge clk);
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    stack_result_t want;
    beats_checked++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result beat with none expected, expected nothing actual %h/%h/%h/%b",
               $time, out_bus.status, out_bus.word_out, out_bus.entry_count, out_bus.last);
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", 32'(want.status), 32'(out_bus.status));
    compare_field("word_out", 32'(want.word), 32'(out_bus.word_out));
    compare_field("entry_count", 32'(want.count), 32'(out_bus.entry_count));
    compare_field("last", 32'(want.last), 32'(out_bus.last));
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) check_result();
  end

  always @(negedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
             $time, quiet_cycles, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_PUSH;
    in_bus.push_value = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_word_extremes();
    test_single_entry();
    test_overflow();
    test_random_traffic();

    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations (%0d dumps), checked %0d result beats.",
             ops_sent, dumps_sent, beats_checked);
    $display("Saw %0d refused pushes on a full stack and %0d empty-stack underflows, %0d errors.",
             overflows_seen, underflows_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
